FILE: rtl/rlne_pkg.sv
// Shared types, constants and register codes for the run-length note encoder.
package rlne_pkg;

	localparam int unsigned DEFAULT_TICK_BITS = 16;
	localparam int unsigned SYM_BITS = 3;
	localparam int unsigned NOTE_BITS = 16;
	localparam int unsigned DELAY_BITS = 8;
	localparam int unsigned INTERVAL_BITS = 10;
	localparam int unsigned ADDR_BITS = 4;
	localparam int unsigned DATA_BITS = 32;

	localparam int unsigned MS_PER_SEC = 1000;
	localparam int unsigned DELAY_MAX = 255;
	localparam int unsigned DELAY_SAT_PROD = (DELAY_MAX + 1) * MS_PER_SEC;
	localparam int unsigned DIV_PRESHIFT = 3;
	localparam int unsigned DIV_ODD = MS_PER_SEC >> DIV_PRESHIFT;
	localparam int unsigned DIV_IN_BITS = 15;
	localparam int unsigned RECIP_SHIFT = 22;
	localparam int unsigned RECIP_MUL = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
	localparam int unsigned RECIP_BITS = 16;

	localparam logic [DELAY_BITS-1:0] RST_START_DELAY = 8'd0;
	localparam logic [INTERVAL_BITS-1:0] RST_TICK_INTERVAL = 10'd50;
	localparam logic [NOTE_BITS-1:0] RST_MAX_NOTE_TICKS = 16'd255;
	localparam logic [NOTE_BITS-1:0] RST_MAX_NOTES = 16'd1024;

	typedef enum logic [1:0] {
		REG_START_DELAY,
		REG_TICK_INTERVAL,
		REG_MAX_NOTE_TICKS,
		REG_MAX_NOTES
	} reg_idx_t;

	typedef struct packed {
		logic [DELAY_BITS-1:0] start_delay_sec;
		logic [INTERVAL_BITS-1:0] tick_interval_ms;
		logic [NOTE_BITS-1:0] max_note_ticks;
		logic [NOTE_BITS-1:0] note_limit;
	} cfg_t;

	typedef struct packed {
		logic [SYM_BITS-1:0] symbol;
		logic [NOTE_BITS-1:0] start;
		logic [NOTE_BITS-1:0] length;
		logic [NOTE_BITS-1:0] index;
		logic limit;
		logic last;
	} note_t;

endpackage

FILE: rtl/rlne_cfg.sv
// Configuration register file with its APB-style access port.
module rlne_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rlne_pkg::ADDR_BITS-1:0] paddr,
	input  logic [rlne_pkg::DATA_BITS-1:0] pwdata,
	output logic [rlne_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	output rlne_pkg::cfg_t cfg
);
	import rlne_pkg::*;

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr;

	assign idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay_sec <= RST_START_DELAY;
			cfg_q.tick_interval_ms <= RST_TICK_INTERVAL;
			cfg_q.max_note_ticks <= RST_MAX_NOTE_TICKS;
			cfg_q.note_limit <= RST_MAX_NOTES;
		end else if (wr) begin
			case (idx)
				REG_START_DELAY: cfg_q.start_delay_sec <= pwdata[DELAY_BITS-1:0];
				REG_TICK_INTERVAL: cfg_q.tick_interval_ms <= pwdata[INTERVAL_BITS-1:0];
				REG_MAX_NOTE_TICKS: cfg_q.max_note_ticks <= pwdata[NOTE_BITS-1:0];
				REG_MAX_NOTES: cfg_q.note_limit <= pwdata[NOTE_BITS-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_DELAY: prdata = DATA_BITS'(cfg_q.start_delay_sec);
			REG_TICK_INTERVAL: prdata = DATA_BITS'(cfg_q.tick_interval_ms);
			REG_MAX_NOTE_TICKS: prdata = DATA_BITS'(cfg_q.max_note_ticks);
			REG_MAX_NOTES: prdata = DATA_BITS'(cfg_q.note_limit);
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/rlne_tracker.sv
// Run tracking, note splitting and count limiting, with a two-slot note register.
module rlne_tracker #(
	parameter int unsigned TICK_BITS = rlne_pkg::DEFAULT_TICK_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  rlne_pkg::cfg_t cfg,
	input  logic sym_valid,
	output logic sym_ready,
	input  logic [rlne_pkg::SYM_BITS-1:0] symbol,
	input  logic end_of_song,
	output logic note_valid,
	input  logic note_ready,
	output rlne_pkg::note_t note,
	output logic [TICK_BITS-1:0] note_first
);
	import rlne_pkg::*;

	logic [SYM_BITS-1:0] run_value_q;
	logic [TICK_BITS-1:0] run_begin_q;
	logic [NOTE_BITS-1:0] run_count_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [TICK_BITS-1:0] first_tick_q;
	logic first_seen_q;
	logic [NOTE_BITS-1:0] emitted_q;
	logic truncated_q;

	logic [1:0] slot_v_s1;
	note_t note0_s1;
	note_t note1_s1;
	logic [TICK_BITS-1:0] first0_s1;
	logic [TICK_BITS-1:0] first1_s1;

	logic accept;
	logic pop;
	logic change;
	logic cond0;
	logic cond1;
	logic capture;
	logic split;
	logic closing;
	logic ok0;
	logic ok1;
	logic lim0;
	logic lim1;
	logic tr1;
	logic [SYM_BITS-1:0] rv1;
	logic [TICK_BITS-1:0] rb1;
	logic [NOTE_BITS-1:0] rc1;
	logic [NOTE_BITS-1:0] rc2;
	logic [NOTE_BITS-1:0] limit;
	logic fs1;
	logic [TICK_BITS-1:0] ft1;
	logic [NOTE_BITS-1:0] cnt1;
	logic [NOTE_BITS-1:0] cnt2;
	logic [TICK_BITS-1:0] diff0;
	logic [TICK_BITS-1:0] diff1;
	note_t n0;
	note_t n1;
	logic [SYM_BITS-1:0] rv_n;
	logic [TICK_BITS-1:0] rb_n;
	logic [NOTE_BITS-1:0] rc_n;
	logic [TICK_BITS-1:0] tp_n;
	logic [TICK_BITS-1:0] ft_n;
	logic fs_n;
	logic [NOTE_BITS-1:0] cnt_n;
	logic tr_n;

	assign pop = note_valid && note_ready;
	assign accept = sym_valid && sym_ready;
	assign note_valid = |slot_v_s1;
	assign sym_ready = !(|slot_v_s1) || (pop && !(&slot_v_s1));
	assign note = slot_v_s1[0] ? note0_s1 : note1_s1;
	assign note_first = slot_v_s1[0] ? first0_s1 : first1_s1;

	always_comb begin
		change = symbol != run_value_q;
		cond0 = change && (run_value_q != '0) && (run_count_q != '0);
		rv1 = change ? symbol : run_value_q;
		rb1 = change ? tick_q : run_begin_q;
		rc1 = change ? '0 : run_count_q;
		capture = change && (symbol != '0) && !first_seen_q;
		fs1 = first_seen_q || capture;
		ft1 = capture ? tick_q : first_tick_q;
		rc2 = rc1 + NOTE_BITS'(1);
		limit = (cfg.max_note_ticks == '0) ? NOTE_BITS'(1) : cfg.max_note_ticks;
		split = (rv1 != '0) && (rc2 >= limit);
		closing = end_of_song && (rv1 != '0) && !split && (rc2 != '0);
		cond1 = split || closing;

		ok0 = cond0 && !truncated_q && (emitted_q < cfg.note_limit);
		cnt1 = emitted_q + NOTE_BITS'(ok0);
		lim0 = ok0 && (cnt1 >= cfg.note_limit);
		tr1 = truncated_q || lim0;
		ok1 = cond1 && !tr1 && (cnt1 < cfg.note_limit);
		cnt2 = cnt1 + NOTE_BITS'(ok1);
		lim1 = ok1 && (cnt2 >= cfg.note_limit);

		diff0 = run_begin_q - first_tick_q;
		diff1 = rb1 - ft1;

		n0.symbol = run_value_q;
		n0.start = NOTE_BITS'(diff0);
		n0.length = run_count_q;
		n0.index = emitted_q;
		n0.limit = lim0;
		n0.last = end_of_song && !ok1;

		n1.symbol = rv1;
		n1.start = NOTE_BITS'(diff1);
		n1.length = rc2;
		n1.index = cnt1;
		n1.limit = lim1;
		n1.last = end_of_song;

		tp_n = tick_q + TICK_BITS'(1);
		if (end_of_song) begin
			rv_n = '0;
			rb_n = '0;
			rc_n = '0;
			tp_n = '0;
			ft_n = '0;
			fs_n = 1'b0;
			cnt_n = '0;
			tr_n = 1'b0;
		end else begin
			rv_n = rv1;
			rb_n = split ? (rb1 + TICK_BITS'(rc2)) : rb1;
			rc_n = split ? '0 : rc2;
			ft_n = ft1;
			fs_n = fs1;
			cnt_n = cnt2;
			tr_n = tr1 || lim1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_begin_q <= '0;
			run_count_q <= '0;
			tick_q <= '0;
			first_tick_q <= '0;
			first_seen_q <= 1'b0;
			emitted_q <= '0;
			truncated_q <= 1'b0;
		end else if (accept) begin
			run_value_q <= rv_n;
			run_begin_q <= rb_n;
			run_count_q <= rc_n;
			tick_q <= tp_n;
			first_tick_q <= ft_n;
			first_seen_q <= fs_n;
			emitted_q <= cnt_n;
			truncated_q <= tr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_s1 <= '0;
		end else if (accept) begin
			slot_v_s1 <= {ok1, ok0};
		end else if (pop) begin
			if (slot_v_s1[0]) begin
				slot_v_s1[0] <= 1'b0;
			end else begin
				slot_v_s1[1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			note0_s1 <= n0;
			note1_s1 <= n1;
			first0_s1 <= first_tick_q;
			first1_s1 <= ft1;
		end
	end

endmodule

FILE: rtl/rlne_delay.sv
// Start delay computation and the result register.
module rlne_delay #(
	parameter int unsigned TICK_BITS = rlne_pkg::DEFAULT_TICK_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  rlne_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  rlne_pkg::note_t in_note,
	input  logic [TICK_BITS-1:0] in_first,
	output logic out_valid,
	input  logic out_ready,
	output rlne_pkg::note_t out_note,
	output logic [rlne_pkg::DELAY_BITS-1:0] delay
);
	import rlne_pkg::*;

	localparam int unsigned PROD_BITS = TICK_BITS + INTERVAL_BITS;
	localparam int unsigned QF_BITS = DIV_IN_BITS + RECIP_BITS;

	logic valid_s2;
	note_t note_s2;
	logic [PROD_BITS-1:0] prod_s2;
	logic valid_s3;
	note_t note_s3;
	logic [DELAY_BITS-1:0] delay_s3;

	logic adv3;
	logic [PROD_BITS-1:0] first_ext;
	logic [PROD_BITS-1:0] interval_ext;
	logic [PROD_BITS-1:0] prod_n;
	logic sat;
	logic [QF_BITS-1:0] div_ext;
	logic [QF_BITS-1:0] recip_ext;
	logic [QF_BITS-1:0] quot_full;
	logic [DELAY_BITS-1:0] delay_n;

	assign adv3 = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || adv3;
	assign out_valid = valid_s3;
	assign out_note = note_s3;
	assign delay = delay_s3;

	assign first_ext = PROD_BITS'(in_first);
	assign interval_ext = PROD_BITS'(cfg.tick_interval_ms);
	assign prod_n = first_ext * interval_ext;

	// A product below the saturation point is divided by 1000 as a shift by 3
	// and a reciprocal multiply for 125, exact over that range.
	always_comb begin
		sat = prod_s2 >= PROD_BITS'(DELAY_SAT_PROD);
		div_ext = QF_BITS'(prod_s2[DIV_PRESHIFT +: DIV_IN_BITS]);
		recip_ext = QF_BITS'(RECIP_MUL);
		quot_full = div_ext * recip_ext;
		if (cfg.start_delay_sec != '0) begin
			delay_n = cfg.start_delay_sec;
		end else if (sat) begin
			delay_n = DELAY_BITS'(DELAY_MAX);
		end else begin
			delay_n = quot_full[RECIP_SHIFT +: DELAY_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			note_s2 <= in_note;
			prod_s2 <= prod_n;
		end
		if (adv3 && valid_s2) begin
			note_s3 <= note_s2;
			delay_s3 <= delay_n;
		end
	end

endmodule

FILE: rtl/run_length_note_encoder_top.sv
// A request accepted by the tracker is held in its note slots and then passes the delay stages s2
// and s3 before it reaches the outputs, where it is taken while note_ready is high.
// A second note from the same request follows the first, out of the second slot.
// Throughput: one request per cycle while each causes at most one note and note_ready stays
// high; a request that causes two notes holds the two-slot note register until both are taken.
// Reset: arst_n clears run state, counters and all valid flags at once;
// configuration registers return to their documented defaults.
module run_length_note_encoder_top #(
	parameter int unsigned TICK_BITS = rlne_pkg::DEFAULT_TICK_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rlne_pkg::ADDR_BITS-1:0] paddr,
	input  logic [rlne_pkg::DATA_BITS-1:0] pwdata,
	output logic [rlne_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	input  logic sym_valid,
	output logic sym_ready,
	input  logic [rlne_pkg::SYM_BITS-1:0] symbol,
	input  logic end_of_song,
	output logic note_valid,
	input  logic note_ready,
	output logic [rlne_pkg::SYM_BITS-1:0] note_symbol,
	output logic [rlne_pkg::NOTE_BITS-1:0] note_start,
	output logic [rlne_pkg::NOTE_BITS-1:0] note_length,
	output logic [rlne_pkg::NOTE_BITS-1:0] note_index,
	output logic [rlne_pkg::DELAY_BITS-1:0] delay_sec,
	output logic limit_reached,
	output logic last_note
);
	import rlne_pkg::*;

	cfg_t cfg;
	logic trk_valid;
	logic trk_ready;
	note_t trk_note;
	logic [TICK_BITS-1:0] trk_first;
	note_t out_note;

	rlne_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	rlne_tracker #(.TICK_BITS(TICK_BITS)) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.symbol(symbol),
		.end_of_song(end_of_song),
		.note_valid(trk_valid),
		.note_ready(trk_ready),
		.note(trk_note),
		.note_first(trk_first)
	);

	rlne_delay #(.TICK_BITS(TICK_BITS)) u_delay (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(trk_valid),
		.in_ready(trk_ready),
		.in_note(trk_note),
		.in_first(trk_first),
		.out_valid(note_valid),
		.out_ready(note_ready),
		.out_note(out_note),
		.delay(delay_sec)
	);

	assign note_symbol = out_note.symbol;
	assign note_start = out_note.start;
	assign note_length = out_note.length;
	assign note_index = out_note.index;
	assign limit_reached = out_note.limit;
	assign last_note = out_note.last;

endmodule

FILE: rtl/rlne_checker.sv
// Port-level checks on the note output of the encoder, bound to its top level.
module rlne_checker (
	input logic clk,
	input logic arst_n,
	input logic note_valid,
	input logic note_ready,
	input logic [rlne_pkg::SYM_BITS-1:0] note_symbol,
	input logic [rlne_pkg::NOTE_BITS-1:0] note_start,
	input logic [rlne_pkg::NOTE_BITS-1:0] note_length,
	input logic [rlne_pkg::NOTE_BITS-1:0] note_index,
	input logic [rlne_pkg::DELAY_BITS-1:0] delay_sec,
	input logic limit_reached,
	input logic last_note
);
	import rlne_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		note_valid && !note_ready |=> note_valid && $stable(note_symbol) &&
		$stable(note_start) && $stable(note_length) && $stable(note_index) &&
		$stable(delay_sec) && $stable(limit_reached) && $stable(last_note))
		else $error("A stalled note changed or was dropped.");

	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !note_valid)
		else $error("A note appeared right after reset.");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		note_valid |-> (note_symbol != '0) && (note_length != '0))
		else $error("A note has an empty symbol or zero length.");

	a_new_song: assert property (@(posedge clk) disable iff (!arst_n)
		note_valid && note_ready && last_note |=> !note_valid || (note_index == '0))
		else $error("The first note of a new song does not restart its index.");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		note_valid && note_ready && !last_note && !limit_reached |=>
		!note_valid || (note_index == '0) ||
		(note_index == NOTE_BITS'($past(note_index) + NOTE_BITS'(1))))
		else $error("Note index skipped or repeated within a song.");

endmodule

bind run_length_note_encoder_top rlne_checker u_rlne_checker (.*);

FILE: test/run_length_note_encoder_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the run-length note encoder: directed table, random songs, APB setup.
module run_length_note_encoder_top_test;
	import rlne_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_ITEMS = 1240;
	localparam int unsigned MAX_SHOWN = 10;
	localparam int unsigned PHASES = 7;
	localparam int unsigned PRESSURE_PHASE = 2;
	localparam int unsigned ROWS = 17;
	localparam int unsigned LONG_LEAD = 300;
	localparam int unsigned LONG_RUN = 40;

	typedef struct packed {
		logic [SYM_BITS-1:0] symbol;
		logic [NOTE_BITS-1:0] start;
		logic [NOTE_BITS-1:0] length;
		logic [NOTE_BITS-1:0] index;
		logic [DELAY_BITS-1:0] delay;
		logic limit;
		logic last;
	} note_rec_t;

	typedef struct packed {
		logic [SYM_BITS-1:0] symbol;
		logic eos;
		logic typed;
		note_rec_t note;
	} tick_row_t;

	localparam tick_row_t TICK_TABLE [ROWS] = '{
		'{3'd0, 1'b0, 1'b0, '0},
		'{3'd7, 1'b0, 1'b0, '0},
		'{3'd7, 1'b1, 1'b1, '{3'd7, 16'd0, 16'd2, 16'd0, 8'd0, 1'b0, 1'b1}},
		'{3'd1, 1'b1, 1'b1, '{3'd1, 16'd0, 16'd1, 16'd0, 8'd0, 1'b0, 1'b1}},
		'{3'd0, 1'b1, 1'b0, '0},
		'{3'd3, 1'b0, 1'b0, '0},
		'{3'd4, 1'b0, 1'b1, '{3'd3, 16'd0, 16'd1, 16'd0, 8'd0, 1'b0, 1'b0}},
		'{3'd0, 1'b0, 1'b1, '{3'd4, 16'd1, 16'd1, 16'd1, 8'd0, 1'b0, 1'b0}},
		'{3'd5, 1'b0, 1'b0, '0},
		'{3'd2, 1'b1, 1'b0, '0},
		'{3'd6, 1'b0, 1'b0, '0},
		'{3'd6, 1'b0, 1'b0, '0},
		'{3'd6, 1'b0, 1'b0, '0},
		'{3'd2, 1'b0, 1'b1, '{3'd6, 16'd0, 16'd3, 16'd0, 8'd0, 1'b0, 1'b0}},
		'{3'd2, 1'b1, 1'b1, '{3'd2, 16'd3, 16'd2, 16'd1, 8'd0, 1'b0, 1'b1}},
		'{3'd0, 1'b0, 1'b0, '0},
		'{3'd0, 1'b1, 1'b0, '0}
	};

	localparam cfg_t PHASE_RULES [PHASES] = '{
		'{8'd0, 10'd50, 16'd255, 16'd1024},
		'{8'd0, 10'd1023, 16'd3, 16'd65535},
		'{8'd200, 10'd1, 16'd1, 16'd40},
		'{8'd0, 10'd0, 16'd0, 16'd5},
		'{8'd255, 10'd1000, 16'd65535, 16'd0},
		'{8'd0, 10'd777, 16'd7, 16'd300},
		'{8'd1, 10'd1023, 16'd2, 16'd65535}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;
	logic sym_valid;
	logic sym_ready;
	logic [SYM_BITS-1:0] symbol;
	logic end_of_song;
	logic note_valid;
	logic note_ready;
	logic [SYM_BITS-1:0] note_symbol;
	logic [NOTE_BITS-1:0] note_start;
	logic [NOTE_BITS-1:0] note_length;
	logic [NOTE_BITS-1:0] note_index;
	logic [DELAY_BITS-1:0] delay_sec;
	logic limit_reached;
	logic last_note;

	cfg_t rules;
	logic [SYM_BITS-1:0] run_sym;
	logic [NOTE_BITS-1:0] run_start;
	logic [NOTE_BITS-1:0] run_len;
	logic [NOTE_BITS-1:0] tick_pos;
	logic [NOTE_BITS-1:0] first_tick;
	logic [NOTE_BITS-1:0] issued;
	logic seen_first;
	logic capped;
	note_rec_t step_out [2];
	int unsigned step_cnt;

	note_rec_t expected_notes [$];
	int unsigned mismatches;
	int unsigned notes_checked;
	int unsigned requests_sent;
	int unsigned songs_closed;
	int unsigned idle_cycles;
	bit quiet;
	bit hold_request;

	run_length_note_encoder_top DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic clear_song();
		run_sym = '0;
		run_start = '0;
		run_len = '0;
		tick_pos = '0;
		first_tick = '0;
		issued = '0;
		seen_first = 1'b0;
		capped = 1'b0;
	endtask

	function automatic logic [DELAY_BITS-1:0] song_delay();
		longint unsigned product;
		if (rules.start_delay_sec != 0)
			return rules.start_delay_sec;
		product = first_tick;
		product = product * rules.tick_interval_ms / MS_PER_SEC;
		return product > DELAY_MAX ? DELAY_BITS'(DELAY_MAX) : product[DELAY_BITS-1:0];
	endfunction

	task automatic issue_note(input logic [NOTE_BITS-1:0] len);
		note_rec_t made;
		if (capped || issued >= rules.note_limit || len == 0)
			return;
		made.symbol = run_sym;
		made.start = run_start - first_tick;
		made.length = len;
		made.index = issued;
		made.delay = song_delay();
		issued = issued + 1'b1;
		made.limit = issued >= rules.note_limit;
		if (made.limit)
			capped = 1'b1;
		made.last = 1'b0;
		step_out[step_cnt] = made;
		step_cnt++;
	endtask

	task automatic encode_tick(input logic [SYM_BITS-1:0] sym, input logic eos);
		logic [NOTE_BITS-1:0] piece;
		piece = rules.max_note_ticks == 0 ? NOTE_BITS'(1) : rules.max_note_ticks;
		step_cnt = 0;
		if (sym != run_sym) begin
			if (run_sym != 0 && run_len > 0)
				issue_note(run_len);
			run_sym = sym;
			run_start = tick_pos;
			run_len = '0;
			if (sym != 0 && !seen_first) begin
				seen_first = 1'b1;
				first_tick = tick_pos;
			end
		end
		run_len = run_len + 1'b1;
		if (run_sym != 0 && run_len >= piece) begin
			issue_note(run_len);
			run_start = run_start + run_len;
			run_len = '0;
		end
		tick_pos = tick_pos + 1'b1;
		if (eos) begin
			if (run_sym != 0 && run_len > 0)
				issue_note(run_len);
			if (step_cnt > 0)
				step_out[step_cnt-1].last = 1'b1;
			clear_song();
		end
	endtask

	task automatic send_tick(input logic [SYM_BITS-1:0] sym, input logic eos,
			input logic typed, input note_rec_t typed_note);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk) sym_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk) begin
			sym_valid <= 1'b1;
			symbol <= sym;
			end_of_song <= eos;
		end
		do @(posedge clk); while (!sym_ready);
		encode_tick(sym, eos);
		if (typed) begin
			expected_notes.push_back(typed_note);
		end else begin
			for (int k = 0; k < step_cnt; k++)
				expected_notes.push_back(step_out[k]);
		end
		requests_sent++;
		if (eos)
			songs_closed++;
	endtask

	task automatic program_reg(input reg_idx_t which, input logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] readback;
		@(negedge clk) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {which, 2'b00};
			pwdata <= value;
		end
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (which)
			REG_START_DELAY: begin
				rules.start_delay_sec = value[DELAY_BITS-1:0];
				readback = DATA_BITS'(rules.start_delay_sec);
			end
			REG_TICK_INTERVAL: begin
				rules.tick_interval_ms = value[INTERVAL_BITS-1:0];
				readback = DATA_BITS'(rules.tick_interval_ms);
			end
			REG_MAX_NOTE_TICKS: begin
				rules.max_note_ticks = value[NOTE_BITS-1:0];
				readback = DATA_BITS'(rules.max_note_ticks);
			end
			default: begin
				rules.note_limit = value[NOTE_BITS-1:0];
				readback = DATA_BITS'(rules.note_limit);
			end
		endcase
		@(negedge clk) begin
			penable <= 1'b0;
			pwrite <= 1'b0;
		end
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("register %s read back %0h, expected %0h", which.name(), prdata, readback);
		end
		@(negedge clk) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic program_rules(input cfg_t want);
		program_reg(REG_START_DELAY, DATA_BITS'(want.start_delay_sec));
		program_reg(REG_TICK_INTERVAL, DATA_BITS'(want.tick_interval_ms));
		program_reg(REG_MAX_NOTE_TICKS, DATA_BITS'(want.max_note_ticks));
		program_reg(REG_MAX_NOTES, DATA_BITS'(want.note_limit));
	endtask

	task automatic drain_notes();
		@(negedge clk) sym_valid <= 1'b0;
		while (expected_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_songs(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		logic [SYM_BITS-1:0] sym;
		logic eos;
		sent = 0;
		while (sent < budget) begin
			sym = SYM_BITS'($urandom_range(0, 7));
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(8, 24) : $urandom_range(1, 4);
				eos = $urandom_range(0, 14) == 0;
				for (int k = 0; k < len; k++)
					send_tick(sym, eos && k == len - 1, 1'b0, '0);
				sent += len;
			end else begin
				send_tick(sym, $urandom_range(0, 3) == 0, 1'b0, '0);
				sent++;
			end
		end
	endtask

	task automatic check_note();
		note_rec_t got;
		note_rec_t want;
		got = {note_symbol, note_start, note_length, note_index, delay_sec, limit_reached,
			last_note};
		notes_checked++;
		if (expected_notes.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("note with no request behind it: sym %0d start %0d length %0d index %0d",
					got.symbol, got.start, got.length, got.index);
		end else begin
			want = expected_notes.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display(
						"exp/got sym %0d/%0d st %0d/%0d len %0d/%0d idx %0d/%0d dly %0d/%0d lim %b/%b last %b/%b",
						want.symbol, got.symbol, want.start, got.start, want.length, got.length,
						want.index, got.index, want.delay, got.delay, want.limit, got.limit,
						want.last, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || (sym_valid && sym_ready) || (note_valid && note_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("run_length_note_encoder_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin : note_sink
		int unsigned stall;
		bit held;
		held = 1'b0;
		note_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (hold_request && !held) begin
				stall = HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall > 0) begin
				@(negedge clk) note_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) note_ready <= 1'b1;
			do @(posedge clk); while (!note_valid);
			check_note();
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sym_valid = 1'b0;
		symbol = '0;
		end_of_song = 1'b0;
		rules = '{RST_START_DELAY, RST_TICK_INTERVAL, RST_MAX_NOTE_TICKS, RST_MAX_NOTES};
		clear_song();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int r = 0; r < ROWS; r++)
			send_tick(TICK_TABLE[r].symbol, TICK_TABLE[r].eos, TICK_TABLE[r].typed,
				TICK_TABLE[r].note);
		drain_notes();

		// Songs may run on across a register change, so limits also move mid-song.
		for (int p = 0; p < PHASES; p++) begin
			program_rules(PHASE_RULES[p]);
			quiet = p % 3 == 1;
			if (p == PRESSURE_PHASE)
				hold_request = 1'b1;
			random_songs(RANDOM_ITEMS / PHASES);
			drain_notes();
		end

		// A late first note saturates the computed delay, and its long run splits into pieces.
		program_rules('{8'd0, 10'd1000, 16'd16, 16'd1024});
		quiet = 1'b1;
		send_tick(3'd0, 1'b1, 1'b0, '0);
		for (int k = 0; k < LONG_LEAD; k++)
			send_tick(3'd0, 1'b0, 1'b0, '0);
		for (int k = 0; k < LONG_RUN; k++)
			send_tick(3'd5, 1'b0, 1'b0, '0);
		for (int k = 0; k < 3; k++)
			send_tick(3'd2, k == 2, 1'b0, '0);
		quiet = 1'b0;
		drain_notes();

		$display("Sent %0d symbol requests in %0d closed songs under %0d register settings.",
			requests_sent, songs_closed, PHASES + 2);
		$display("Checked %0d notes, %0d mismatches, %0d notes still owed.",
			notes_checked, mismatches, expected_notes.size());
		if (mismatches == 0 && expected_notes.size() == 0)
			$display("run_length_note_encoder_top_test: done, clean");
		else
			$display("run_length_note_encoder_top_test: done, errors");
		$finish;
	end

endmodule
